// ===== rtl/modbus_tcp_request_framer_macros.svh =====
// ----------------------------------------------------------------------------
// Modbus TCP request framer assertion macros
// Concurrent checks that compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef MODBUS_TCP_REQUEST_FRAMER_MACROS_SVH
`define MODBUS_TCP_REQUEST_FRAMER_MACROS_SVH

`ifndef SYNTH
// same-cycle implication
`define MTF_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// next-cycle implication
`define MTF_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define MTF_ASSERT_IMP(label, clk, rst, ante, cons)
`define MTF_ASSERT_NXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== rtl/mtf_pkg.sv =====
// ----------------------------------------------------------------------------
// Modbus TCP request framer package
// Shared types, function codes and frame constants.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mtf_pkg;

  localparam int MAX_BYTES  = 13;
  localparam int CNT_W      = 4;
  localparam int S_TDATA_W  = 56;

  localparam logic ACTION_HEADER = 1'b0;
  localparam logic ACTION_DATA   = 1'b1;

  localparam logic [7:0] FC_READ_COILS      = 8'd1;
  localparam logic [7:0] FC_READ_DISCRETE   = 8'd2;
  localparam logic [7:0] FC_READ_HOLDING    = 8'd3;
  localparam logic [7:0] FC_READ_INPUT      = 8'd4;
  localparam logic [7:0] FC_WRITE_COIL      = 8'd5;
  localparam logic [7:0] FC_WRITE_REGISTER  = 8'd6;
  localparam logic [7:0] FC_WRITE_COILS     = 8'd15;
  localparam logic [7:0] FC_WRITE_REGISTERS = 8'd16;

  localparam logic [7:0]  UNIT_ID_RESET  = 8'd1;
  localparam logic [15:0] TID_RESET      = 16'd1;
  localparam logic [15:0] LEN_SHORT      = 16'd6;
  localparam logic [15:0] LEN_MULTI_BASE = 16'd7;
  localparam logic [11:0] BYTE_COUNT_MAX = 12'd255;
  localparam logic [11:0] COIL_ROUND     = 12'd7;

  localparam logic [CNT_W-1:0] CNT_SHORT_FRAME = CNT_W'(12);
  localparam logic [CNT_W-1:0] CNT_MULTI_HEAD  = CNT_W'(13);

  typedef struct packed {
    logic        action;
    logic [7:0]  function_code;
    logic [15:0] start_address;
    logic [10:0] quantity;
    logic [15:0] data_word;
  } item_t;

  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] frame_bytes;
    logic [CNT_W-1:0]          count;
    logic                      frame_end;
    logic                      bad_request;
  } desc_t;

endpackage

// ===== rtl/mtf_input_reg.sv =====
// ----------------------------------------------------------------------------
// Input register
// Captures one item from the slave stream and holds it for the builder.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtf_input_reg
  import mtf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // function_code[7:0], start_address[23:8], quantity[34:24], data_word[50:35], zero pad
  input  logic [S_TDATA_W-1:0] s_tdata,
  // action[0]
  input  logic                 s_tuser,
  input  logic                 take,
  output logic                 item_valid,
  output item_t                item
);

  assign s_tready = !item_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      item_valid <= 1'b1;
    end else if (take) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      item.action        <= s_tuser;
      item.function_code <= s_tdata[7:0];
      item.start_address <= s_tdata[23:8];
      item.quantity      <= s_tdata[34:24];
      item.data_word     <= s_tdata[50:35];
    end
  end

endmodule

// ===== rtl/mtf_builder.sv =====
// ----------------------------------------------------------------------------
// Frame builder
// Holds the request state and turns one item into a frame descriptor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "modbus_tcp_request_framer_macros.svh"

module mtf_builder
  import mtf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data,
  input  logic       item_valid,
  input  item_t      item,
  input  logic       space,
  output logic       take,
  output logic       desc_valid,
  output desc_t      desc
);

  logic [7:0]  unit_id;
  logic [15:0] transaction_id;
  logic [7:0]  active_function;
  logic [10:0] items_left;
  logic [2:0]  bit_index;
  logic [7:0]  coil_accumulator;
  logic        in_payload;

  logic [15:0] transaction_id_next;
  logic [7:0]  active_function_next;
  logic [10:0] items_left_next;
  logic [2:0]  bit_index_next;
  logic [7:0]  coil_accumulator_next;
  logic        in_payload_next;

  logic [11:0] coil_sum;
  logic [11:0] byte_count;
  logic [15:0] frame_len;
  logic [10:0] left_dec;
  logic [7:0]  acc_merged;
  logic [2:0]  bit_inc;

  assign cfg_ready = 1'b1;

  assign coil_sum   = {1'b0, item.quantity} + COIL_ROUND;
  assign byte_count = (item.function_code == FC_WRITE_COILS) ?
                      {3'b000, coil_sum[11:3]} : {item.quantity, 1'b0};
  assign frame_len  = LEN_MULTI_BASE + {4'b0000, byte_count};
  assign left_dec   = items_left - 11'd1;
  assign acc_merged = coil_accumulator | ({7'b0000000, item.data_word[0]} << bit_index);
  assign bit_inc    = bit_index + 3'd1;

  always_comb begin
    desc                  = '0;
    transaction_id_next   = transaction_id;
    active_function_next  = active_function;
    items_left_next       = items_left;
    bit_index_next        = bit_index;
    coil_accumulator_next = coil_accumulator;
    in_payload_next       = in_payload;

    desc.frame_bytes[0] = transaction_id[15:8];
    desc.frame_bytes[1] = transaction_id[7:0];
    desc.frame_bytes[4] = LEN_SHORT[15:8];
    desc.frame_bytes[5] = LEN_SHORT[7:0];
    desc.frame_bytes[6] = unit_id;
    desc.frame_bytes[7] = item.function_code;
    desc.frame_bytes[8] = item.start_address[15:8];
    desc.frame_bytes[9] = item.start_address[7:0];

    if (item.action == ACTION_HEADER) begin
      in_payload_next       = 1'b0;
      items_left_next       = '0;
      bit_index_next        = '0;
      coil_accumulator_next = '0;
      unique case (item.function_code) inside
        FC_READ_COILS, FC_READ_DISCRETE, FC_READ_HOLDING, FC_READ_INPUT: begin
          if (item.quantity == '0) begin
            desc.frame_bytes = '0;
            desc.count       = CNT_W'(1);
            desc.bad_request = 1'b1;
          end else begin
            desc.frame_bytes[10] = {5'b00000, item.quantity[10:8]};
            desc.frame_bytes[11] = item.quantity[7:0];
            desc.count           = CNT_SHORT_FRAME;
            desc.frame_end       = 1'b1;
            transaction_id_next  = transaction_id + 16'd1;
          end
        end
        FC_WRITE_COIL, FC_WRITE_REGISTER: begin
          desc.frame_bytes[10] = item.data_word[15:8];
          desc.frame_bytes[11] = item.data_word[7:0];
          desc.count           = CNT_SHORT_FRAME;
          desc.frame_end       = 1'b1;
          transaction_id_next  = transaction_id + 16'd1;
        end
        FC_WRITE_COILS, FC_WRITE_REGISTERS: begin
          if (item.quantity == '0 || byte_count > BYTE_COUNT_MAX) begin
            desc.frame_bytes = '0;
            desc.count       = CNT_W'(1);
            desc.bad_request = 1'b1;
          end else begin
            desc.frame_bytes[4]  = frame_len[15:8];
            desc.frame_bytes[5]  = frame_len[7:0];
            desc.frame_bytes[10] = {5'b00000, item.quantity[10:8]};
            desc.frame_bytes[11] = item.quantity[7:0];
            desc.frame_bytes[12] = byte_count[7:0];
            desc.count           = CNT_MULTI_HEAD;
            transaction_id_next  = transaction_id + 16'd1;
            active_function_next = item.function_code;
            items_left_next      = item.quantity;
            in_payload_next      = 1'b1;
          end
        end
        default: begin
          desc.frame_bytes = '0;
          desc.count       = CNT_W'(1);
          desc.bad_request = 1'b1;
        end
      endcase
    end else begin
      desc.frame_bytes = '0;
      if (!in_payload || items_left == '0) begin
        in_payload_next = 1'b0;
      end else begin
        items_left_next = left_dec;
        if (active_function == FC_WRITE_REGISTERS) begin
          desc.frame_bytes[0] = item.data_word[15:8];
          desc.frame_bytes[1] = item.data_word[7:0];
          desc.count          = CNT_W'(2);
          desc.frame_end      = (left_dec == '0);
          if (left_dec == '0) begin
            in_payload_next = 1'b0;
          end
        end else if (bit_inc == '0 || left_dec == '0) begin
          desc.frame_bytes[0]   = acc_merged;
          desc.count            = CNT_W'(1);
          desc.frame_end        = (left_dec == '0);
          coil_accumulator_next = '0;
          bit_index_next        = bit_inc;
          if (left_dec == '0) begin
            in_payload_next = 1'b0;
            bit_index_next  = '0;
          end
        end else begin
          coil_accumulator_next = acc_merged;
          bit_index_next        = bit_inc;
        end
      end
    end
  end

  assign desc_valid = item_valid && (desc.count != '0);
  assign take       = item_valid && ((desc.count == '0) || space);

  always_ff @(posedge clk) begin
    if (rst) begin
      unit_id <= UNIT_ID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unit_id <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      transaction_id   <= TID_RESET;
      active_function  <= '0;
      items_left       <= '0;
      bit_index        <= '0;
      coil_accumulator <= '0;
      in_payload       <= 1'b0;
    end else if (take) begin
      transaction_id   <= transaction_id_next;
      active_function  <= active_function_next;
      items_left       <= items_left_next;
      bit_index        <= bit_index_next;
      coil_accumulator <= coil_accumulator_next;
      in_payload       <= in_payload_next;
    end
  end

  `MTF_ASSERT_NXT(a_tid_advance, clk, rst, take && (desc.count >= CNT_SHORT_FRAME),
                  transaction_id == $past(transaction_id) + 16'd1)
  `MTF_ASSERT_NXT(a_tid_hold_bad, clk, rst, take && desc.bad_request,
                  $stable(transaction_id) && !in_payload)
  `MTF_ASSERT_NXT(a_end_closes, clk, rst, take && desc.frame_end,
                  !in_payload && (items_left == '0))

endmodule

// ===== rtl/mtf_serializer.sv =====
// ----------------------------------------------------------------------------
// Byte serializer
// Holds one frame descriptor and shifts its bytes out on the master stream.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mtf_serializer
  import mtf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       desc_valid,
  input  desc_t      desc,
  output logic       space,
  output logic       m_tvalid,
  input  logic       m_tready,
  // out_byte[7:0]
  output logic [7:0] m_tdata,
  output logic       m_tlast,
  // bad_request[0]
  output logic       m_tuser
);

  logic [MAX_BYTES-1:0][7:0] frame_bytes;
  logic [CNT_W-1:0]          count;
  logic                      frame_end;
  logic                      bad_request;

  assign space    = (count == '0) || ((count == CNT_W'(1)) && m_tready);
  assign m_tvalid = (count != '0);
  assign m_tdata  = frame_bytes[0];
  assign m_tlast  = (count == CNT_W'(1)) && frame_end;
  assign m_tuser  = bad_request;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (desc_valid && space) begin
      count <= desc.count;
    end else if (m_tvalid && m_tready) begin
      count <= count - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (desc_valid && space) begin
      frame_bytes <= desc.frame_bytes;
      frame_end   <= desc.frame_end;
      bad_request <= desc.bad_request;
    end else if (m_tvalid && m_tready) begin
      frame_bytes <= frame_bytes >> 8;
    end
  end

endmodule

// ===== rtl/modbus_tcp_request_framer.sv =====
// ----------------------------------------------------------------------------
// Modbus TCP request framer
// Serializes request items into Modbus TCP frame bytes, one byte per output item.
// ----------------------------------------------------------------------------
// Slave stream: one item per handshake; tuser is the action (header or data),
// tdata carries function code, address, quantity and data word.
// Master stream: one frame byte per handshake; tlast marks the last byte of a
// frame, tuser marks a rejected request (a single zero byte, no tlast).
// Config channel: cfg_valid/cfg_ready/cfg_data writes the unit id; write
// only while no item is in flight.
// Path: an item is captured in the input register, passes the combinational
// builder and is loaded into the byte shift register once that has space; the
// first byte is valid as soon as it sits in the shift register. The shift
// register emits one byte per cycle while m_tready is high, so a read or
// single-write header is 12 bytes, a multiple-write header 13, a register item
// 2, a coil item 1 or none. Items that emit nothing pass at one a cycle.
// A new item is held in the input register while bytes still drain.
// Stall: when m_tready is low the current byte holds and the input side
// fills and then deasserts s_tready.
// Reset: sync, active high; transaction id 1, unit id 1, no frame pending.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module modbus_tcp_request_framer
  import mtf_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // function_code[7:0], start_address[23:8], quantity[34:24], data_word[50:35], zero pad
  input  logic [S_TDATA_W-1:0] s_tdata,
  // action[0]
  input  logic                 s_tuser,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // out_byte[7:0]
  output logic [7:0]           m_tdata,
  output logic                 m_tlast,
  // bad_request[0]
  output logic                 m_tuser,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [7:0]           cfg_data
);

  logic  take;
  logic  item_valid;
  item_t item;
  logic  space;
  logic  desc_valid;
  desc_t desc;

  mtf_input_reg u_input_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  mtf_builder u_builder (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .item_valid (item_valid),
    .item       (item),
    .space      (space),
    .take       (take),
    .desc_valid (desc_valid),
    .desc       (desc)
  );

  mtf_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .desc_valid (desc_valid),
    .desc       (desc),
    .space      (space),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .m_tuser    (m_tuser)
  );

endmodule
